[rtl/lab_pkg.sv]
// Shared types and constants for the life automaton board.
package lab_pkg;

	localparam int CFG_W = 7;
	localparam int CFG_IDX_W = 1;
	localparam int SIZE_W = 9;
	localparam int ADDR_W = 6;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'd1;
	localparam logic [CFG_W-1:0] SIZE_RESET = 7'd10;

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_STEP = 2'd1;
	localparam logic [1:0] MODE_READ = 2'd2;
	localparam logic [1:0] MODE_CLEAR = 2'd3;

	typedef struct packed {
		logic [1:0] mode;
		logic [ADDR_W-1:0] row;
		logic [ADDR_W-1:0] col;
		logic cell_in;
	} lab_req_t;

	typedef struct packed {
		logic cell_out;
		logic status;
	} lab_rsp_t;

	typedef struct packed {
		logic wr;
		logic step;
		logic clr;
		logic val;
	} lab_cmd_t;

endpackage

[rtl/lab_cell.sv]
// One board row: holds its cell bits and computes its next generation from its neighbors.
module lab_cell
	import lab_pkg::*;
#(
	parameter int COLS = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  lab_cmd_t        cmd,
	input  logic            sel,
	input  logic            act,
	input  logic [COLS-1:0] col_act,
	input  logic [COLS-1:0] col_hot,
	input  logic [COLS-1:0] up,
	input  logic [COLS-1:0] dn,
	output logic [COLS-1:0] row,
	output logic            rd_bit
);

	localparam logic [3:0] BORN_COUNT = 4'd3;
	localparam logic [3:0] KEEP_COUNT = 4'd2;

	logic [COLS-1:0] bits_q;
	logic [COLS-1:0] next_bits;
	logic [COLS+1:0] up_p;
	logic [COLS+1:0] own_p;
	logic [COLS+1:0] dn_p;

	function automatic logic [3:0] count8(input logic [7:0] v);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < 8; i++) begin
			n = n + {3'b000, v[i]};
		end
		return n;
	endfunction

	assign row = act ? (bits_q & col_act) : '0;
	assign rd_bit = sel & (|(bits_q & col_hot));

	assign up_p = {1'b0, up, 1'b0};
	assign own_p = {1'b0, row, 1'b0};
	assign dn_p = {1'b0, dn, 1'b0};

	always_comb begin
		logic [3:0] n;
		n = '0;
		next_bits = '0;
		for (int c = 0; c < COLS; c++) begin
			n = count8({up_p[c], up_p[c+1], up_p[c+2], own_p[c], own_p[c+2],
				dn_p[c], dn_p[c+1], dn_p[c+2]});
			next_bits[c] = act & col_act[c] &
				((n == BORN_COUNT) | ((n == KEEP_COUNT) & row[c]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= '0;
		end else if (cmd.clr) begin
			bits_q <= '0;
		end else if (cmd.step) begin
			bits_q <= next_bits;
		end else if (cmd.wr && sel) begin
			bits_q <= (bits_q & ~col_hot) | (col_hot & {COLS{cmd.val}});
		end
	end

endmodule

[rtl/life_automaton_board_core.sv]
// Top level of the life automaton board: request handling, size registers and the row chain.
//
// Requests arrive on req_valid/req_ready with a lab_req_t payload: write a cell, advance
// one generation (rule B3/S23, no wrap-around), read a cell, or clear the board. Every
// request yields exactly one response on rsp_valid/rsp_ready carrying the read value and
// an out-of-area flag. A write or read outside the active area is flagged and ignored.
// The board is a chain of row cells; each row sees the rows above and below it, so a
// whole generation is computed combinationally and stored in the row registers together.
// A request is registered in the command stage at acceptance and executed once the output
// register is free, when its response is loaded into the output register.
// The single command stage in front of the row chain holds one request at a time and accepts
// the next only once that request has executed. When the receiver stalls, the response
// is held and one further request may be accepted and wait in the command stage; it executes
// once the held response is taken. The size registers are written through
// cfg_we/cfg_idx/cfg_data; the user must do so only while the block is idle, which the block
// does not enforce. Reset clears every cell, sets both sizes to ten and empties both stages.
module life_automaton_board_core
	import lab_pkg::*;
#(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  lab_req_t             req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output lab_rsp_t             rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam logic [SIZE_W-1:0] ROW_LIM = SIZE_W'(MAX_ROWS);
	localparam logic [SIZE_W-1:0] COL_LIM = SIZE_W'(MAX_COLS);

	logic [CFG_W-1:0] rows_q;
	logic [CFG_W-1:0] cols_q;
	logic [SIZE_W-1:0] rows_ext;
	logic [SIZE_W-1:0] cols_ext;
	logic [SIZE_W-1:0] rows_lim;
	logic [SIZE_W-1:0] cols_lim;

	logic s1_valid_q;
	lab_req_t req_s1;
	logic rsp_valid_q;
	lab_rsp_t rsp_q;

	logic fire;
	logic in_area;
	logic is_addr;
	lab_cmd_t cmd;

	logic [MAX_ROWS-1:0] row_act;
	logic [MAX_ROWS-1:0] row_hot;
	logic [MAX_COLS-1:0] col_act;
	logic [MAX_COLS-1:0] col_hot;
	logic [MAX_COLS-1:0] rows_w [MAX_ROWS];
	logic [MAX_ROWS-1:0] rd_w;
	logic [MAX_ROWS-1:0] row_nz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= SIZE_RESET;
			cols_q <= SIZE_RESET;
		end else if (cfg_we) begin
			if (cfg_idx == REG_ROWS) begin
				rows_q <= cfg_data;
			end else if (cfg_idx == REG_COLS) begin
				cols_q <= cfg_data;
			end
		end
	end

	assign rows_ext = {{(SIZE_W-CFG_W){1'b0}}, rows_q};
	assign cols_ext = {{(SIZE_W-CFG_W){1'b0}}, cols_q};
	assign rows_lim = (rows_ext > ROW_LIM) ? ROW_LIM : rows_ext;
	assign cols_lim = (cols_ext > COL_LIM) ? COL_LIM : cols_ext;

	assign in_area = ({{(SIZE_W-ADDR_W){1'b0}}, req_s1.row} < rows_lim) &&
		({{(SIZE_W-ADDR_W){1'b0}}, req_s1.col} < cols_lim);
	assign is_addr = (req_s1.mode == MODE_WRITE) || (req_s1.mode == MODE_READ);

	assign fire = s1_valid_q && (!rsp_valid_q || rsp_ready);
	assign req_ready = !s1_valid_q;

	assign cmd.wr = fire && (req_s1.mode == MODE_WRITE) && in_area;
	assign cmd.step = fire && (req_s1.mode == MODE_STEP);
	assign cmd.clr = fire && (req_s1.mode == MODE_CLEAR);
	assign cmd.val = req_s1.cell_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (req_valid && req_ready) begin
			s1_valid_q <= 1'b1;
		end else if (fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q.cell_out <= (req_s1.mode == MODE_READ) && in_area && (|rd_w);
			rsp_q.status <= is_addr && !in_area;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	for (genvar c = 0; c < MAX_COLS; c++) begin : g_col
		assign col_act[c] = SIZE_W'(c) < cols_lim;
		assign col_hot[c] = {{(SIZE_W-ADDR_W){1'b0}}, req_s1.col} == SIZE_W'(c);
	end

	for (genvar r = 0; r < MAX_ROWS; r++) begin : g_row
		logic [MAX_COLS-1:0] up;
		logic [MAX_COLS-1:0] dn;

		assign row_act[r] = SIZE_W'(r) < rows_lim;
		assign row_hot[r] = {{(SIZE_W-ADDR_W){1'b0}}, req_s1.row} == SIZE_W'(r);
		assign row_nz[r] = |rows_w[r];

		if (r == 0) begin : g_top
			assign up = '0;
		end else begin : g_mid_up
			assign up = rows_w[r-1];
		end

		if (r == MAX_ROWS - 1) begin : g_bot
			assign dn = '0;
		end else begin : g_mid_dn
			assign dn = rows_w[r+1];
		end

		lab_cell #(
			.COLS(MAX_COLS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.sel     (row_hot[r]),
			.act     (row_act[r]),
			.col_act (col_act),
			.col_hot (col_hot),
			.up      (up),
			.dn      (dn),
			.row     (rows_w[r]),
			.rd_bit  (rd_w[r])
		);
	end

`ifndef SYNTHESIS
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr |=> (row_nz == '0))
		else $error("Board not empty after a clear request.");

	a_flag_outside: assert property (@(posedge clk) disable iff (!arst_n)
		fire && is_addr && !in_area |=> rsp_valid_q && rsp_q.status && !rsp_q.cell_out)
		else $error("Out-of-area request not flagged.");

	a_no_flag_board_op: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !is_addr |=> rsp_valid_q && !rsp_q.status && !rsp_q.cell_out)
		else $error("Advance or clear request gave a nonzero response.");

	a_rsp_kept: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp_ready |=> rsp_valid_q && $stable(rsp_q))
		else $error("Held response was overwritten.");
`endif

endmodule
